// File: rtl/core/cplm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cplm_pkg
// Shared types, constants and helpers of the class pattern line matcher.
// ----------------------------------------------------------------------------
package cplm_pkg;

    localparam int MAX_PATTERN_DEF = 24;
    localparam int MAX_LINE_DEF    = 256;
    localparam int QUEUE_DEPTH     = 2;

    localparam int LINE_W    = 20;
    localparam int COL_OUT_W = 8;
    localparam int LEN_W     = 5;
    localparam int WORD_W    = 60;
    localparam int ELEM_W    = 10;
    localparam int CFG_IDX_W = 3;
    localparam int WORD_NUM  = 4;

    localparam logic [LINE_W-1:0] LINE_MAX = {LINE_W{1'b1}};
    localparam logic [7:0] LINE_FEED = 8'h0A;

    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_LO_A  = 8'h61;
    localparam logic [7:0] CHAR_LO_Z  = 8'h7A;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
    localparam logic [7:0] CHAR_UNDER = 8'h5F;

    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD_A = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD_B = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD_C = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD_D = 3'd4;

    typedef enum logic [1:0] {
        KIND_LITERAL  = 2'd0,
        KIND_DIGIT    = 2'd1,
        KIND_BOUNDARY = 2'd2,
        KIND_NEVER    = 2'd3
    } kind_t;

    typedef struct packed {
        logic [7:0] value;
        kind_t      kind;
        logic       used;
    } elem_t;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CHAR_0) && (b <= CHAR_9);
    endfunction

    function automatic logic is_word(input logic [7:0] b);
        return is_digit(b) || ((b >= CHAR_LO_A) && (b <= CHAR_LO_Z)) ||
               ((b >= CHAR_UP_A) && (b <= CHAR_UP_Z)) || (b == CHAR_UNDER);
    endfunction

endpackage

// File: rtl/core/cplm_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cplm_fifo
// Small register queue with first-word-fall-through read.
// ----------------------------------------------------------------------------
module cplm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [DEPTH-1:0][WIDTH-1:0] mem_reg;
    logic [PW-1:0]               wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]               rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0]             count_reg, count_next;
    logic                        do_push, do_pop;

    assign full    = (count_reg == CNTW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: rtl/core/cplm_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cplm_cfg
// Pattern registers and the per-element window offsets derived from them.
// ----------------------------------------------------------------------------
module cplm_cfg
    import cplm_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF,
    parameter int IDXW        = $clog2(MAX_PATTERN + 2)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [CFG_IDX_W-1:0]              cfg_index,
    input  logic [WORD_W-1:0]                 cfg_data,
    output elem_t [MAX_PATTERN-1:0]           elem,
    output logic [MAX_PATTERN-1:0][IDXW-1:0]  elem_rem,
    output logic [IDXW-1:0]                   width_used,
    output logic                              busy
);

    logic [LEN_W-1:0]                length_reg;
    logic [WORD_NUM-1:0][WORD_W-1:0] word_reg;
    logic [LEN_W-1:0]                len_eff;
    logic [WORD_NUM*WORD_W-1:0]      flat;
    logic [MAX_PATTERN-1:0]          consumed;
    logic [MAX_PATTERN-1:0][IDXW-1:0] rem_reg, rem_next;
    logic [IDXW-1:0]                 settle_reg;
    logic                            wr;

    assign cfg_ready  = 1'b1;
    assign wr         = cfg_valid && cfg_ready;
    assign busy       = (settle_reg != '0);
    assign len_eff    = (length_reg > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : length_reg;
    assign flat       = word_reg;
    assign elem_rem   = rem_reg;
    assign width_used = rem_reg[0];

    always_comb
    begin
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            elem[i].value = flat[ELEM_W*i +: 8];
            elem[i].kind  = kind_t'(flat[ELEM_W*i + 8 +: 2]);
            elem[i].used  = (LEN_W'(i) < len_eff);
            consumed[i]   = elem[i].used && (elem[i].kind != KIND_BOUNDARY);
        end
    end

    // Count consumed elements from each element to the end, one link per cycle
    always_comb
    begin
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            if (i == MAX_PATTERN - 1)
            begin
                rem_next[i] = IDXW'(consumed[i]);
            end
            else
            begin
                rem_next[i] = rem_reg[i+1] + IDXW'(consumed[i]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg <= '0;
            word_reg   <= '0;
            rem_reg    <= '0;
            settle_reg <= '0;
        end
        else
        begin
            rem_reg <= rem_next;
            if (wr)
            begin
                settle_reg <= IDXW'(MAX_PATTERN + 1);
            end
            else if (busy)
            begin
                settle_reg <= settle_reg - 1'b1;
            end
            if (wr)
            begin
                unique case (cfg_index)
                    CFG_PATTERN_LENGTH: length_reg  <= cfg_data[LEN_W-1:0];
                    CFG_PATTERN_WORD_A: word_reg[0] <= cfg_data;
                    CFG_PATTERN_WORD_B: word_reg[1] <= cfg_data;
                    CFG_PATTERN_WORD_C: word_reg[2] <= cfg_data;
                    CFG_PATTERN_WORD_D: word_reg[3] <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

// File: rtl/core/cplm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cplm_front
// Line and column tracking, byte window, and match job setup per request.
// ----------------------------------------------------------------------------
module cplm_front
    import cplm_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF,
    parameter int MAX_LINE    = MAX_LINE_DEF,
    parameter int IDXW        = $clog2(MAX_PATTERN + 2)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  logic [7:0]                        text_byte,
    input  logic                              new_file,
    input  logic                              end_of_file,
    input  logic [IDXW-1:0]                   width_used,
    output logic [MAX_PATTERN+1:0][7:0]       job_bytes,
    output logic [MAX_PATTERN+1:0]            job_valid,
    output logic                              job_eligible,
    output logic [LINE_W-1:0]                 job_line,
    output logic [COL_OUT_W-1:0]              job_col
);

    localparam int CW = $clog2(MAX_LINE + 1);

    logic [MAX_PATTERN:0][7:0] win_reg;
    logic [CW-1:0]             col_reg, col_next, col_eff, col_start;
    logic [LINE_W-1:0]         line_reg, line_next, line_eff;
    logic                      is_close, keep_byte;

    assign col_eff   = new_file ? '0 : col_reg;
    assign line_eff  = new_file ? '0 : line_reg;
    assign is_close  = end_of_file || (text_byte == LINE_FEED);
    assign keep_byte = !is_close && (col_eff < CW'(MAX_LINE));
    assign col_start = col_eff - CW'(width_used);
    assign job_col   = COL_OUT_W'(col_start);
    assign job_line  = (line_eff == LINE_MAX) ? LINE_MAX : line_eff + 1'b1;

    // A closing request shifts in an outside-the-line slot so that both cases
    // see the pattern end one slot before the newest entry.
    always_comb
    begin
        job_bytes[0] = text_byte;
        job_valid[0] = !is_close;
        for (int k = 1; k <= MAX_PATTERN + 1; k++)
        begin
            job_bytes[k] = win_reg[k-1];
            job_valid[k] = (CW'(k) <= col_eff);
        end
    end

    always_comb
    begin
        col_next  = col_eff;
        line_next = line_eff;
        if (is_close)
        begin
            job_eligible = (col_eff != '0) && (width_used != '0) &&
                           (col_eff >= CW'(width_used));
            col_next     = '0;
            if (((col_eff != '0) || !end_of_file) && (line_eff != LINE_MAX))
            begin
                line_next = line_eff + 1'b1;
            end
        end
        else if (keep_byte)
        begin
            job_eligible = (col_eff >= CW'(width_used));
            col_next     = col_eff + 1'b1;
        end
        else
        begin
            // drop bytes past the line limit
            job_eligible = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            line_reg <= '0;
        end
        else if (accept)
        begin
            col_reg  <= col_next;
            line_reg <= line_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && keep_byte)
        begin
            win_reg <= job_bytes[MAX_PATTERN:0];
        end
    end

endmodule

// File: rtl/core/cplm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cplm_back
// Parallel element compare over one queued job, result push on match.
// ----------------------------------------------------------------------------
module cplm_back
    import cplm_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF,
    parameter int IDXW        = $clog2(MAX_PATTERN + 2)
) (
    input  logic                              job_present,
    input  logic [MAX_PATTERN+1:0][7:0]       job_bytes,
    input  logic [MAX_PATTERN+1:0]            job_valid,
    input  logic                              job_eligible,
    input  logic [LINE_W-1:0]                 job_line,
    input  logic [COL_OUT_W-1:0]              job_col,
    input  elem_t [MAX_PATTERN-1:0]           elem,
    input  logic [MAX_PATTERN-1:0][IDXW-1:0]  elem_rem,
    input  logic                              res_full,
    output logic                              job_pop,
    output logic                              res_push,
    output logic [LINE_W+COL_OUT_W-1:0]       res_data
);

    logic [MAX_PATTERN-1:0] ok;
    logic [IDXW-1:0]        idx_at [MAX_PATTERN];
    logic [IDXW-1:0]        idx_before [MAX_PATTERN];
    logic                   hit;

    always_comb
    begin
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            idx_at[i]     = elem_rem[i];
            idx_before[i] = elem_rem[i] + 1'b1;
            if (!elem[i].used)
            begin
                ok[i] = 1'b1;
            end
            else
            begin
                unique case (elem[i].kind)
                    KIND_LITERAL:
                        ok[i] = job_bytes[idx_at[i]] == elem[i].value;
                    KIND_DIGIT:
                        ok[i] = is_digit(job_bytes[idx_at[i]]);
                    KIND_BOUNDARY:
                        ok[i] = (job_valid[idx_at[i]] && is_word(job_bytes[idx_at[i]])) !=
                                (job_valid[idx_before[i]] &&
                                 is_word(job_bytes[idx_before[i]]));
                    KIND_NEVER:
                        ok[i] = 1'b0;
                    default:
                        ok[i] = 1'b0;
                endcase
            end
        end
    end

    assign hit      = job_eligible && (&ok);
    assign job_pop  = job_present && !res_full;
    assign res_push = job_pop && hit;
    assign res_data = {job_line, job_col};

endmodule

// File: rtl/core/class_pattern_line_matcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// class_pattern_line_matcher
// Line-oriented pattern search with literal, digit and word-boundary elements.
// ----------------------------------------------------------------------------
// Takes one text byte per cycle while full is low and reports, in order,
// the line number and start column of every place in a line where the
// loaded pattern matches. A byte request is classified in the front part
// and queued as a match job; the back part compares all pattern elements
// of one job at once, so the sustained rate is one byte per cycle unless
// results back up or a configuration write settles. Two queues of two
// entries each, one for jobs and one for results, let the input side keep
// running while a result waits to be popped. After any configuration write
// the block reports full while the per-element window offsets ripple
// through their register chain.
// ----------------------------------------------------------------------------
module class_pattern_line_matcher
    import cplm_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF,
    parameter int MAX_LINE    = MAX_LINE_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [7:0]            text_byte,
    input  logic                  new_file,
    input  logic                  end_of_file,
    output logic                  empty,
    input  logic                  pop,
    output logic [LINE_W-1:0]     line_number,
    output logic [COL_OUT_W-1:0]  start_column,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [WORD_W-1:0]     cfg_data
);

    localparam int IDXW  = $clog2(MAX_PATTERN + 2);
    localparam int SLOTS = MAX_PATTERN + 2;
    localparam int JOB_W = SLOTS * 8 + SLOTS + 1 + LINE_W + COL_OUT_W;
    localparam int RES_W = LINE_W + COL_OUT_W;

    elem_t [MAX_PATTERN-1:0]          elem;
    logic [MAX_PATTERN-1:0][IDXW-1:0] elem_rem;
    logic [IDXW-1:0]                  width_used;
    logic                             cfg_busy;

    logic                             accept;
    logic [SLOTS-1:0][7:0]            f_bytes, b_bytes;
    logic [SLOTS-1:0]                 f_valid, b_valid;
    logic                             f_eligible, b_eligible;
    logic [LINE_W-1:0]                f_line, b_line;
    logic [COL_OUT_W-1:0]             f_col, b_col;
    logic [JOB_W-1:0]                 job_wr, job_rd;
    logic                             job_full, job_empty, job_pop;
    logic                             res_full, res_push;
    logic [RES_W-1:0]                 res_wr, res_rd;

    assign full   = job_full || cfg_busy;
    assign accept = push && !full;

    cplm_cfg #(
        .MAX_PATTERN (MAX_PATTERN),
        .IDXW        (IDXW)
    ) u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .elem       (elem),
        .elem_rem   (elem_rem),
        .width_used (width_used),
        .busy       (cfg_busy)
    );

    cplm_front #(
        .MAX_PATTERN (MAX_PATTERN),
        .MAX_LINE    (MAX_LINE),
        .IDXW        (IDXW)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .text_byte    (text_byte),
        .new_file     (new_file),
        .end_of_file  (end_of_file),
        .width_used   (width_used),
        .job_bytes    (f_bytes),
        .job_valid    (f_valid),
        .job_eligible (f_eligible),
        .job_line     (f_line),
        .job_col      (f_col)
    );

    assign job_wr = {f_bytes, f_valid, f_eligible, f_line, f_col};

    cplm_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_job_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (accept),
        .wr_data (job_wr),
        .full    (job_full),
        .pop     (job_pop),
        .rd_data (job_rd),
        .empty   (job_empty)
    );

    assign {b_bytes, b_valid, b_eligible, b_line, b_col} = job_rd;

    cplm_back #(
        .MAX_PATTERN (MAX_PATTERN),
        .IDXW        (IDXW)
    ) u_back (
        .job_present  (!job_empty),
        .job_bytes    (b_bytes),
        .job_valid    (b_valid),
        .job_eligible (b_eligible),
        .job_line     (b_line),
        .job_col      (b_col),
        .elem         (elem),
        .elem_rem     (elem_rem),
        .res_full     (res_full),
        .job_pop      (job_pop),
        .res_push     (res_push),
        .res_data     (res_wr)
    );

    cplm_fifo #(
        .WIDTH (RES_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (res_wr),
        .full    (res_full),
        .pop     (pop),
        .rd_data (res_rd),
        .empty   (empty)
    );

    assign {line_number, start_column} = res_rd;

endmodule
